### rtl/hbd_pkg.sv
// ----------------------------------------------------------------------------
// hbd_pkg: shared types and codes of the block Huffman decompressor
// Holds the result kind codes and the stream phase type.
// ----------------------------------------------------------------------------
package hbd_pkg;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_TREE = 2'd2;
  localparam logic [1:0] KIND_MARK = 2'd3;

  localparam logic [7:0] MARK_END   = 8'd0;
  localparam logic [7:0] MARK_BLOCK = 8'd1;

  typedef enum logic [2:0] {
    PH_MARKER,
    PH_COUNT,
    PH_TREE,
    PH_LEAF,
    PH_DECODE,
    PH_DRAIN,
    PH_HALT
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] symbol;
    logic       block_end;
  } res_t;

endpackage

### rtl/huffman_block_decompressor_top.sv
// ----------------------------------------------------------------------------
// huffman_block_decompressor_top: bit-serial block Huffman decompressor
// Rebuilds each block's preorder tree and walks it one code bit per step.
// ----------------------------------------------------------------------------
// One request is one stream byte (op 0) or a drain (op 1). The block works on
// one request at a time and takes it in an idle cycle. A count byte takes only
// that cycle; a marker byte that ends the stream also passes the flush state.
// A tree or code byte is worked up to its 8 bits, one bit step at a time,
// where a code bit in the walk goes through S_BIT and S_WALK (child table
// read is registered) and a finished leaf passes S_DLV and S_DLV2 for each
// stack level it closes (stack read). A drain emits one symbol per cycle
// while the output is free, up to MAX_RESULTS_PER_ITEM, then sees the end of
// the run and flushes. A new request is taken only once the current one is
// through and the block is back in idle.
// Results pass through a hold slot (so run_last is known) and an output
// register; when the output is stalled the bit engine waits. After an end or
// an error result every later request is taken and dropped until reset.
module huffman_block_decompressor_top #(
  parameter int MAX_INTERNAL_NODES   = 255,
  parameter int MAX_RESULTS_PER_ITEM = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_symbol,
  output logic       out_block_end,
  output logic       out_run_last
);

  localparam int DW = $clog2(MAX_RESULTS_PER_ITEM + 1);
  localparam logic [7:0] MAXN = 8'(MAX_INTERNAL_NODES);
  localparam logic [DW-1:0] MAXR = DW'(MAX_RESULTS_PER_ITEM);

  typedef enum logic [2:0] {
    S_IDLE, S_BIT, S_WALK, S_DLV, S_DLV2, S_DRAIN, S_FLUSH
  } state_t;

  // tree tables and the build stack
  logic [8:0] left_mem  [256];
  logic [8:0] right_mem [256];
  logic [8:0] stack_mem [256];

  state_t           state_r, state_nxt;
  hbd_pkg::phase_t  phase_r, phase_nxt;
  logic [7:0]       sh_r, sh_nxt;
  logic [3:0]       bitcnt_r, bitcnt_nxt;
  logic [7:0]       depth_r, depth_nxt;
  logic [7:0]       nnode_r, nnode_nxt;
  logic [8:0]       root_r, root_nxt;
  logic [8:0]       walk_r, walk_nxt;
  logic [8:0]       dv_r, dv_nxt;
  logic [23:0]      cnt_r, cnt_nxt;
  logic [7:0]       lb_r, lb_nxt;
  logic [2:0]       lbc_r, lbc_nxt;
  logic [DW-1:0]    dn_r, dn_nxt;

  logic             pend_v_r, pend_v_nxt;
  hbd_pkg::res_t    pend_r, pend_nxt;
  logic             ov_r;
  hbd_pkg::res_t    ores_r;
  logic             olast_r;

  logic [8:0] l_rd_r, r_rd_r, st_rd_r;
  logic       out_free, can_emit, push, push_last;

  // memory write ports
  logic       st_we, l_we, r_we;
  logic [7:0] st_wa, ch_wa;
  logic [8:0] st_wd, ch_wd;

  // bit step helper outputs
  logic       bit_w;
  logic [8:0] nxt_child;

  assign out_free = !ov_r || !out_stall;
  assign can_emit = !pend_v_r || out_free;
  assign in_stall = (state_r != S_IDLE);
  assign bit_w    = sh_r[7];
  assign nxt_child = bit_w ? r_rd_r : l_rd_r;

  always_ff @(posedge clk) begin
    if (st_we) stack_mem[st_wa] <= st_wd;
    if (l_we)  left_mem[ch_wa]  <= ch_wd;
    if (r_we)  right_mem[ch_wa] <= ch_wd;
    st_rd_r <= stack_mem[depth_r - 8'd1];
    l_rd_r  <= left_mem[walk_r[7:0]];
    r_rd_r  <= right_mem[walk_r[7:0]];
  end

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    sh_nxt     = sh_r;
    bitcnt_nxt = bitcnt_r;
    depth_nxt  = depth_r;
    nnode_nxt  = nnode_r;
    root_nxt   = root_r;
    walk_nxt   = walk_r;
    dv_nxt     = dv_r;
    cnt_nxt    = cnt_r;
    lb_nxt     = lb_r;
    lbc_nxt    = lbc_r;
    dn_nxt     = dn_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    push       = 1'b0;
    push_last  = 1'b0;
    st_we = 1'b0; l_we = 1'b0; r_we = 1'b0;
    st_wa = depth_r; st_wd = 9'd0;
    ch_wa = 8'd0; ch_wd = dv_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op || phase_r == hbd_pkg::PH_DRAIN) begin
            dn_nxt    = '0;
            state_nxt = (phase_r == hbd_pkg::PH_DRAIN) ? S_DRAIN : S_IDLE;
          end else begin
            unique case (phase_r)
              hbd_pkg::PH_MARKER: begin
                if (in_data == hbd_pkg::MARK_BLOCK) begin
                  phase_nxt = hbd_pkg::PH_COUNT;
                  lbc_nxt   = '0;
                  cnt_nxt   = '0;
                end else begin
                  pend_v_nxt = 1'b1;
                  pend_nxt   = '{kind: (in_data == hbd_pkg::MARK_END) ?
                                   hbd_pkg::KIND_END : hbd_pkg::KIND_MARK,
                                 symbol: 8'd0, block_end: 1'b0};
                  phase_nxt  = hbd_pkg::PH_HALT;
                  state_nxt  = S_FLUSH;
                end
              end
              hbd_pkg::PH_COUNT: begin
                cnt_nxt = {cnt_r[15:0], in_data};
                lbc_nxt = lbc_r + 3'd1;
                if (lbc_r == 3'd2) begin
                  lbc_nxt   = '0;
                  depth_nxt = '0;
                  nnode_nxt = '0;
                  phase_nxt = hbd_pkg::PH_TREE;
                end
              end
              hbd_pkg::PH_TREE, hbd_pkg::PH_LEAF, hbd_pkg::PH_DECODE: begin
                sh_nxt     = in_data;
                bitcnt_nxt = 4'd8;
                state_nxt  = S_BIT;
              end
              default: ;
            endcase
          end
        end
      end

      S_BIT: begin
        unique case (phase_r)
          hbd_pkg::PH_TREE: begin
            if (bit_w) begin
              if (nnode_r >= MAXN) begin
                if (can_emit) begin
                  push       = pend_v_r;
                  pend_v_nxt = 1'b1;
                  pend_nxt   = '{kind: hbd_pkg::KIND_TREE, symbol: 8'd0, block_end: 1'b0};
                  phase_nxt  = hbd_pkg::PH_HALT;
                  state_nxt  = S_FLUSH;
                end
              end else begin
                st_we     = 1'b1;
                st_wa     = depth_r;
                st_wd     = {1'b0, nnode_r};
                depth_nxt = depth_r + 8'd1;
                nnode_nxt = nnode_r + 8'd1;
                sh_nxt    = {sh_r[6:0], 1'b0};
                bitcnt_nxt = bitcnt_r - 4'd1;
                state_nxt = (bitcnt_r == 4'd1) ? S_FLUSH : S_BIT;
              end
            end else begin
              phase_nxt  = hbd_pkg::PH_LEAF;
              lb_nxt     = '0;
              lbc_nxt    = '0;
              sh_nxt     = {sh_r[6:0], 1'b0};
              bitcnt_nxt = bitcnt_r - 4'd1;
              state_nxt  = (bitcnt_r == 4'd1) ? S_FLUSH : S_BIT;
            end
          end
          hbd_pkg::PH_LEAF: begin
            lb_nxt  = {lb_r[6:0], bit_w};
            lbc_nxt = lbc_r + 3'd1;
            if (lbc_r == 3'd7) begin
              phase_nxt = hbd_pkg::PH_TREE;
              dv_nxt    = {1'b0, lb_r[6:0], bit_w};
              state_nxt = S_DLV;
            end else begin
              sh_nxt     = {sh_r[6:0], 1'b0};
              bitcnt_nxt = bitcnt_r - 4'd1;
              state_nxt  = (bitcnt_r == 4'd1) ? S_FLUSH : S_BIT;
            end
          end
          default: state_nxt = S_WALK;  // decode: child read in flight
        endcase
      end

      S_WALK: begin
        if (!nxt_child[8]) begin
          if (can_emit) begin
            push       = pend_v_r;
            pend_v_nxt = 1'b1;
            pend_nxt   = '{kind: hbd_pkg::KIND_BYTE, symbol: nxt_child[7:0],
                           block_end: (cnt_r == 24'd1)};
            cnt_nxt    = cnt_r - 24'd1;
            walk_nxt   = root_r;
            sh_nxt     = {sh_r[6:0], 1'b0};
            bitcnt_nxt = bitcnt_r - 4'd1;
            if (cnt_r == 24'd1) begin
              phase_nxt = hbd_pkg::PH_MARKER;
              state_nxt = S_FLUSH;
            end else begin
              state_nxt = (bitcnt_r == 4'd1) ? S_FLUSH : S_BIT;
            end
          end
        end else begin
          walk_nxt   = nxt_child;
          sh_nxt     = {sh_r[6:0], 1'b0};
          bitcnt_nxt = bitcnt_r - 4'd1;
          state_nxt  = (bitcnt_r == 4'd1) ? S_FLUSH : S_BIT;
        end
      end

      S_DLV: begin
        if (depth_r == 8'd0) begin
          // tree complete
          root_nxt = dv_r;
          walk_nxt = dv_r;
          if (cnt_r == 24'd0) begin
            phase_nxt = hbd_pkg::PH_MARKER;
            state_nxt = S_FLUSH;
          end else if (!dv_r[8]) begin
            phase_nxt = hbd_pkg::PH_DRAIN;
            state_nxt = S_FLUSH;
          end else begin
            phase_nxt  = hbd_pkg::PH_DECODE;
            sh_nxt     = {sh_r[6:0], 1'b0};
            bitcnt_nxt = bitcnt_r - 4'd1;
            state_nxt  = (bitcnt_r == 4'd1) ? S_FLUSH : S_BIT;
          end
        end else begin
          state_nxt = S_DLV2;
        end
      end

      S_DLV2: begin
        ch_wa = st_rd_r[7:0];
        ch_wd = dv_r;
        if (!st_rd_r[8]) begin
          l_we       = 1'b1;
          st_we      = 1'b1;
          st_wa      = depth_r - 8'd1;
          st_wd      = {1'b1, st_rd_r[7:0]};
          sh_nxt     = {sh_r[6:0], 1'b0};
          bitcnt_nxt = bitcnt_r - 4'd1;
          state_nxt  = (bitcnt_r == 4'd1) ? S_FLUSH : S_BIT;
        end else begin
          r_we      = 1'b1;
          depth_nxt = depth_r - 8'd1;
          dv_nxt    = {1'b1, st_rd_r[7:0]};
          state_nxt = S_DLV;
        end
      end

      S_DRAIN: begin
        if (dn_r < MAXR && cnt_r != 24'd0) begin
          if (can_emit) begin
            push       = pend_v_r;
            pend_v_nxt = 1'b1;
            pend_nxt   = '{kind: hbd_pkg::KIND_BYTE, symbol: root_r[7:0],
                           block_end: (cnt_r == 24'd1)};
            cnt_nxt    = cnt_r - 24'd1;
            dn_nxt     = dn_r + DW'(1);
          end
        end else begin
          if (cnt_r == 24'd0) phase_nxt = hbd_pkg::PH_MARKER;
          state_nxt = S_FLUSH;
        end
      end

      S_FLUSH: begin
        // hand the held result on as the request's last one
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      phase_r  <= hbd_pkg::PH_MARKER;
      depth_r  <= '0;
      nnode_r  <= '0;
      root_r   <= '0;
      walk_r   <= '0;
      cnt_r    <= '0;
      lb_r     <= '0;
      lbc_r    <= '0;
      bitcnt_r <= '0;
      dn_r     <= '0;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      depth_r  <= depth_nxt;
      nnode_r  <= nnode_nxt;
      root_r   <= root_nxt;
      walk_r   <= walk_nxt;
      cnt_r    <= cnt_nxt;
      lb_r     <= lb_nxt;
      lbc_r    <= lbc_nxt;
      bitcnt_r <= bitcnt_nxt;
      dn_r     <= dn_nxt;
      pend_v_r <= pend_v_nxt;
      if (push) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sh_r   <= sh_nxt;
    dv_r   <= dv_nxt;
    pend_r <= pend_nxt;
    if (push) begin
      ores_r  <= pend_r;
      olast_r <= push_last;
    end
  end

  assign out_valid     = ov_r;
  assign out_kind      = ores_r.kind;
  assign out_symbol    = ores_r.symbol;
  assign out_block_end = ores_r.block_end;
  assign out_run_last  = olast_r;

endmodule

### rtl/hbd_checker.sv
// ----------------------------------------------------------------------------
// hbd_checker: port-level checks of the block Huffman decompressor
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module hbd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic [7:0] out_symbol,
  input logic       out_block_end,
  input logic       out_run_last
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_symbol)
      && $stable(out_run_last))
    else $error("stalled result changed");

  // end and error results close their request
  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != hbd_pkg::KIND_BYTE |-> out_run_last)
    else $error("status result not last of request");

  a_term_sym: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != hbd_pkg::KIND_BYTE |-> out_symbol == 8'd0 && !out_block_end)
    else $error("status result carries data");

  // nothing follows a status result
  a_term_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_kind != hbd_pkg::KIND_BYTE |=> !out_valid)
    else $error("result after end of stream");

endmodule

bind huffman_block_decompressor_top hbd_checker u_hbd_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_kind(out_kind), .out_symbol(out_symbol), .out_block_end(out_block_end),
  .out_run_last(out_run_last)
);
